>>> src/srt_pkg.sv
// Shared types and codes for the slot reservation table.
// Used by srt_ctrl, srt_datapath and slot_reservation_table; no dependencies.
package srt_pkg;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_CLASH    = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   localparam logic       KIND_ADD   = 1'b0;
   localparam logic       KIND_ERASE = 1'b1;

   localparam logic [15:0] IDENT_MAX = 16'hFFFF;

   typedef struct packed {
      logic              kind;
      logic [7:0]        chan;
      logic              chan_given;
      logic              title_given;
      logic signed [7:0] start_slot;
      logic [6:0]        length_slots;
      logic [15:0]       target_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] assigned_id;
      logic [6:0]  entries_used;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic scan_issue;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic addr_last;
      logic quick;
      logic rsp_busy;
   } sts_type;

endpackage

>>> src/srt_ctrl.sv
// Sequencer for the slot reservation table: clearing pass, table scan, commit.
// Depends on srt_pkg; drives srt_datapath through cmd_type / sts_type.
module srt_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  srt_pkg::sts_type sts,
   output srt_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      CLEAR  = 6'b000001,
      IDLE   = 6'b000010,
      CHECK  = 6'b000100,
      SCAN   = 6'b001000,
      DRAIN  = 6'b010000,
      FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.addr_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CHECK;
            end
         end
         CHECK: begin
            if (sts.quick) begin
               state_in = FINISH;
            end else begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.addr_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = FINISH;
         end
         FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = IDLE;
            end
         end
         default: begin
            state_in = CLEAR;
         end
      endcase
   end

endmodule

>>> src/srt_datapath.sv
// Booking memory, scan evaluation, counters and result register.
// Depends on srt_pkg; steered by srt_ctrl.
module srt_datapath #(
   parameter int ENTRIES       = 64,
   parameter int SLOTS_PER_DAY = 96,
   parameter int CHAN_BITS     = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  srt_pkg::cmd_type cmd,
   output srt_pkg::sts_type sts,
   input  srt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srt_pkg::rsp_type rsp_data
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int CB       = (CHAN_BITS < 8) ? CHAN_BITS : 8;
   localparam logic [7:0] SPD = 8'(SLOTS_PER_DAY);

   typedef struct packed {
      logic          valid;
      logic [CB-1:0] chan;
      logic [6:0]    start;
      logic [6:0]    length;
      logic [15:0]   ident;
   } entry_type;

   entry_type mem [ENTRIES];

   srt_pkg::req_type     req_ff;
   srt_pkg::rsp_type     rsp_ff;
   logic                 rsp_valid_ff;
   logic [IDX_BITS-1:0]  addr_ff;
   entry_type            rd_data_ff;
   logic [IDX_BITS-1:0]  rd_idx_ff;
   logic                 rd_live_ff;
   logic                 clash_ff;
   logic                 free_found_ff;
   logic [IDX_BITS-1:0]  free_idx_ff;
   logic                 hit_found_ff;
   logic [IDX_BITS-1:0]  hit_idx_ff;
   logic [CNT_BITS-1:0]  used_ff;
   logic [CNT_BITS-1:0]  used_in;
   logic [15:0]          next_id_ff;
   logic [15:0]          next_id_in;

   logic                 addr_last;
   logic                 invalid;
   logic                 full;
   logic [7:0]           room;
   logic                 overlap;
   logic [7:0]           s1;
   logic [7:0]           l1;
   logic [7:0]           s2;
   logic [7:0]           l2;
   logic                 chan_match;
   logic                 mem_we;
   logic [IDX_BITS-1:0]  mem_wa;
   entry_type            mem_wd;
   logic                 do_write;
   logic [IDX_BITS-1:0]  commit_idx;
   entry_type            commit_entry;
   logic [2:0]           res_status;
   logic [15:0]          res_id;

   assign addr_last = (addr_ff == IDX_BITS'(ENTRIES - 1));

   assign room    = SPD - {1'b0, req_ff.start_slot[6:0]};
   assign invalid = req_ff.start_slot[7] || !req_ff.title_given || !req_ff.chan_given
                    || ({1'b0, req_ff.start_slot[6:0]} >= SPD)
                    || ({1'b0, req_ff.length_slots} > room);
   assign full    = (used_ff >= CNT_BITS'(ENTRIES)) || (next_id_ff == srt_pkg::IDENT_MAX);

   assign sts.addr_last = addr_last;
   assign sts.quick     = (req_ff.kind == srt_pkg::KIND_ADD) && (invalid || full);
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign s1 = {1'b0, req_ff.start_slot[6:0]};
   assign l1 = {1'b0, req_ff.length_slots};
   assign s2 = {1'b0, rd_data_ff.start};
   assign l2 = {1'b0, rd_data_ff.length};
   assign overlap = (s1 == s2) || ((s1 > s2) && (s1 < s2 + l2))
                    || ((s2 > s1) && (s2 < s1 + l1));
   assign chan_match = (rd_data_ff.chan == req_ff.chan[CB-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else if (cmd.capture) begin
         addr_ff <= '0;
      end else if (cmd.clear_step || cmd.scan_issue) begin
         addr_ff <= addr_last ? '0 : addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[addr_ff];
      rd_idx_ff  <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         clash_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         hit_found_ff  <= 1'b0;
      end else if (rd_live_ff) begin
         if (!rd_data_ff.valid) begin
            if (!free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= rd_idx_ff;
            end
         end else begin
            if (chan_match && overlap) begin
               clash_ff <= 1'b1;
            end
            if (!hit_found_ff && rd_data_ff.ident == req_ff.target_id) begin
               hit_found_ff <= 1'b1;
               hit_idx_ff   <= rd_idx_ff;
            end
         end
      end
   end

   always_comb begin
      res_status   = srt_pkg::ST_OK;
      res_id       = '0;
      do_write     = 1'b0;
      commit_idx   = free_idx_ff;
      commit_entry = '0;
      used_in      = used_ff;
      next_id_in   = next_id_ff;
      if (req_ff.kind == srt_pkg::KIND_ADD) begin
         priority if (invalid) begin
            res_status = srt_pkg::ST_INVALID;
         end else if (full) begin
            res_status = srt_pkg::ST_FULL;
         end else if (clash_ff) begin
            res_status = srt_pkg::ST_CLASH;
         end else if (!free_found_ff) begin
            res_status = srt_pkg::ST_FULL;
         end else begin
            next_id_in          = next_id_ff + 16'd1;
            res_id              = next_id_in;
            do_write            = 1'b1;
            commit_entry.valid  = 1'b1;
            commit_entry.chan   = req_ff.chan[CB-1:0];
            commit_entry.start  = req_ff.start_slot[6:0];
            commit_entry.length = req_ff.length_slots;
            commit_entry.ident  = next_id_in;
            used_in             = used_ff + 1'b1;
         end
      end else begin
         commit_idx = hit_idx_ff;
         if (hit_found_ff) begin
            do_write = 1'b1;
            used_in  = used_ff - 1'b1;
         end else begin
            res_status = srt_pkg::ST_NOTFOUND;
         end
      end
   end

   always_comb begin
      mem_we = cmd.clear_step || (cmd.commit && do_write);
      mem_wa = cmd.clear_step ? addr_ff : commit_idx;
      mem_wd = cmd.clear_step ? entry_type'('0) : commit_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         next_id_ff <= '0;
      end else if (cmd.commit) begin
         used_ff    <= used_in;
         next_id_ff <= next_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.status       <= res_status;
         rsp_ff.assigned_id  <= res_id;
         rsp_ff.entries_used <= 7'(used_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/slot_reservation_table.sv
// Slot reservation table top level: joins srt_ctrl and srt_datapath.
// Depends on srt_pkg, srt_ctrl and srt_datapath.
//
// Holds up to ENTRIES bookings, each an interval of quarter-hour slots on a
// channel. An add item is checked for range and presence, then for a full
// table or exhausted ids, then for a clash on the same channel; an erase
// item frees the booking with the given id. Every item gives one result.
// After reset the booking memory is cleared one entry per cycle, and no
// item is taken until that pass ends. Each item is resolved by a scan of
// the booking memory, one entry per cycle, and the next item is accepted
// only once it is committed; an add refused on range or fullness skips the
// scan. A result waits in an output register, and the next item is taken
// while it waits.
module slot_reservation_table #(
   parameter int ENTRIES       = 64,
   parameter int SLOTS_PER_DAY = 96,
   parameter int CHAN_BITS     = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srt_pkg::rsp_type rsp_data
);

   srt_pkg::cmd_type cmd;
   srt_pkg::sts_type sts;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   srt_datapath #(
      .ENTRIES       (ENTRIES),
      .SLOTS_PER_DAY (SLOTS_PER_DAY),
      .CHAN_BITS     (CHAN_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/reservation_checker.sv
// Result checker for slot_reservation_table: keeps its own booking table,
// predicts one result per accepted request item and compares results in order.
// Depends on srt_pkg.
module reservation_checker #(
   parameter int ENTRIES       = 64,
   parameter int SLOTS_PER_DAY = 96,
   parameter int CHAN_BITS     = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  srt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  srt_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_count,
   output int               checked_count,
   output int               newest_id,
   output int               peak_used,
   output int               full_count
);

   bit                   held [ENTRIES];
   logic [CHAN_BITS-1:0] held_chan [ENTRIES];
   int                   held_start [ENTRIES];
   int                   held_length [ENTRIES];
   logic [15:0]          held_ident [ENTRIES];
   logic [15:0]          ident_counter;
   int                   used;

   srt_pkg::rsp_type awaited_results [$];
   srt_pkg::rsp_type want;
   srt_pkg::rsp_type outcome_now;
   int               errors;
   int               checked;
   int               peak;
   int               refused_full;

   function automatic bit slots_clash(input int s1, input int l1,
                                      input int s2, input int l2);
      return (s1 == s2) || (s1 > s2 && s1 < s2 + l2) || (s2 > s1 && s2 < s1 + l1);
   endfunction

   function automatic srt_pkg::rsp_type predict_booking(input srt_pkg::req_type item);
      srt_pkg::rsp_type outcome;
      int               start_at;
      int               free_slot;
      bit               clash;
      outcome   = '0;
      start_at  = $signed(item.start_slot);
      free_slot = -1;
      clash     = 1'b0;
      if (item.kind == srt_pkg::KIND_ADD) begin
         if (start_at < 0 || !item.chan_given || !item.title_given
             || start_at >= SLOTS_PER_DAY
             || int'(item.length_slots) > SLOTS_PER_DAY - start_at) begin
            outcome.status = srt_pkg::ST_INVALID;
         end else if (used >= ENTRIES || ident_counter >= srt_pkg::IDENT_MAX) begin
            outcome.status = srt_pkg::ST_FULL;
         end else begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (!held[i]) begin
                  if (free_slot < 0) free_slot = i;
               end else if (held_chan[i] == item.chan[CHAN_BITS-1:0]
                            && slots_clash(start_at, int'(item.length_slots),
                                           held_start[i], held_length[i])) begin
                  clash = 1'b1;
               end
            end
            if (clash) begin
               outcome.status = srt_pkg::ST_CLASH;
            end else if (free_slot < 0) begin
               outcome.status = srt_pkg::ST_FULL;
            end else begin
               ident_counter          = ident_counter + 16'd1;
               held[free_slot]        = 1'b1;
               held_chan[free_slot]   = item.chan[CHAN_BITS-1:0];
               held_start[free_slot]  = start_at;
               held_length[free_slot] = int'(item.length_slots);
               held_ident[free_slot]  = ident_counter;
               used++;
               outcome.status      = srt_pkg::ST_OK;
               outcome.assigned_id = ident_counter;
            end
         end
      end else begin
         outcome.status = srt_pkg::ST_NOTFOUND;
         for (int i = 0; i < ENTRIES; i++) begin
            if (outcome.status == srt_pkg::ST_NOTFOUND && held[i]
                && held_ident[i] == item.target_id) begin
               held[i] = 1'b0;
               used--;
               outcome.status = srt_pkg::ST_OK;
            end
         end
      end
      outcome.entries_used = 7'(used);
      return outcome;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) held[i] = 1'b0;
         ident_counter = '0;
         used          = 0;
         errors        = 0;
         checked       = 0;
         peak          = 0;
         refused_full  = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: status %0d id %0d used %0d",
                           rsp_data.status, rsp_data.assigned_id, rsp_data.entries_used);
            end else begin
               want = awaited_results.pop_front();
               checked++;
               if (rsp_data.status !== want.status
                   || rsp_data.assigned_id !== want.assigned_id
                   || rsp_data.entries_used !== want.entries_used) begin
                  errors++;
                  if (errors <= 10)
                     $display({"result %0d: expected status %0d id %0d used %0d,",
                               " got status %0d id %0d used %0d"},
                              checked, want.status, want.assigned_id, want.entries_used,
                              rsp_data.status, rsp_data.assigned_id, rsp_data.entries_used);
               end
            end
         end
         if (req_valid && req_ready) begin
            outcome_now     = predict_booking(req_data);
            awaited_results = {awaited_results, outcome_now};
            if (outcome_now.status == srt_pkg::ST_FULL) refused_full++;
            if (used > peak) peak = used;
         end
      end
      mismatch_count <= errors;
      pending_count  <= awaited_results.size();
      checked_count  <= checked;
      newest_id      <= int'(ident_counter);
      peak_used      <= peak;
      full_count     <= refused_full;
   end

endmodule

>>> tb/testbench.sv
// Top of the slot_reservation_table testbench: makes request items, stalls the
// result channel at random and gives the verdict from reservation_checker.
// Depends on srt_pkg, slot_reservation_table and reservation_checker.
module testbench;

   localparam int ENTRIES       = 64;
   localparam int SLOTS_PER_DAY = 96;
   localparam int CHAN_BITS     = 8;
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef enum {PHASE_FILL, PHASE_MIX, PHASE_DRAIN, PHASE_NOISE} phase_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   srt_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   srt_pkg::rsp_type rsp_data;

   bit steady     = 1'b0;
   int sent_count = 0;
   int mismatch_count;
   int pending_count;
   int checked_count;
   int newest_id;
   int peak_used;
   int full_count;

   slot_reservation_table #(
      .ENTRIES       (ENTRIES),
      .SLOTS_PER_DAY (SLOTS_PER_DAY),
      .CHAN_BITS     (CHAN_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   reservation_checker #(
      .ENTRIES       (ENTRIES),
      .SLOTS_PER_DAY (SLOTS_PER_DAY),
      .CHAN_BITS     (CHAN_BITS)
   ) watcher (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .newest_id      (newest_id),
      .peak_used      (peak_used),
      .full_count     (full_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 35);
      end
   end

   function automatic srt_pkg::req_type raw_item();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(srt_pkg::req_type)-1:0];
   endfunction

   function automatic srt_pkg::req_type add_item(input int ch, input int at, input int len,
                                                 input bit has_chan = 1'b1,
                                                 input bit has_title = 1'b1);
      srt_pkg::req_type item;
      item              = '0;
      item.kind         = srt_pkg::KIND_ADD;
      item.chan         = 8'(ch);
      item.chan_given   = has_chan;
      item.title_given  = has_title;
      item.start_slot   = 8'(at);
      item.length_slots = 7'(len);
      item.target_id    = 16'($urandom);
      return item;
   endfunction

   function automatic srt_pkg::req_type erase_item(input int id);
      srt_pkg::req_type item;
      item           = raw_item();
      item.kind      = srt_pkg::KIND_ERASE;
      item.target_id = 16'(id);
      return item;
   endfunction

   function automatic srt_pkg::req_type random_request(input phase_type phase);
      int               add_pct;
      int               at;
      int               ch;
      int               len;
      int               top_id;
      srt_pkg::req_type item;
      case (phase)
         PHASE_FILL: add_pct = 85;
         PHASE_MIX:  add_pct = 50;
         default:    add_pct = 20;
      endcase
      top_id = newest_id;
      if (phase == PHASE_NOISE || $urandom_range(99) < 8) begin
         item = raw_item();
         if (phase == PHASE_NOISE && $urandom_range(1) == 1) begin
            item.chan_given  = 1'b1;
            item.title_given = 1'b1;
         end
      end else if ($urandom_range(99) < add_pct) begin
         at = $urandom_range(SLOTS_PER_DAY - 1);
         if (phase == PHASE_FILL) begin
            ch = $urandom_range(3);
         end else begin
            ch = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7);
         end
         len = ($urandom_range(4) == 0) ? $urandom_range(SLOTS_PER_DAY - at) : $urandom_range(4);
         item = add_item(ch, at, len);
      end else if (top_id == 0 || $urandom_range(9) == 0) begin
         item = erase_item($urandom_range(65535));
      end else if ($urandom_range(1) == 0) begin
         item = erase_item($urandom_range(top_id, 1));
      end else begin
         item = erase_item($urandom_range(top_id, (top_id > 80) ? top_id - 80 : 1));
      end
      return item;
   endfunction

   task automatic send_item(input srt_pkg::req_type item);
      while (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(add_item(0, 0, 0));
      send_item(add_item(0, 0, 5));
      send_item(add_item(0, 95, 1));
      send_item(add_item(1, 95, 2));
      send_item(add_item(1, 96, 0));
      send_item(add_item(1, -1, 0));
      send_item(add_item(1, -128, 0));
      send_item(add_item(1, 127, 0));
      send_item(add_item(2, 10, 3, 1'b0, 1'b1));
      send_item(add_item(2, 10, 3, 1'b1, 1'b0));
      send_item(add_item(255, 10, 20));
      send_item(add_item(255, 20, 5));
      send_item(add_item(255, 5, 6));
      send_item(add_item(255, 5, 5));
      send_item(add_item(255, 15, 0));
      send_item(add_item(255, 30, 0));
      send_item(add_item(254, 10, 20));
      send_item(add_item(7, 0, 96));
      send_item(add_item(8, 0, 127));
      send_item(erase_item(0));
      send_item(erase_item(1));
      send_item(erase_item(1));
      send_item(erase_item(16'hFFFF));
      send_item(add_item(0, 0, 5));
      send_item(add_item(0, 3, 0));

      for (int n = 0; n < 500; n++) send_item(random_request(PHASE_FILL));
      for (int n = 0; n < 700; n++) begin
         steady <= (n >= 200 && n < 450);
         send_item(random_request(PHASE_MIX));
      end
      steady <= 1'b0;
      for (int n = 0; n < 300; n++) send_item(random_request(PHASE_DRAIN));
      for (int n = 0; n < 250; n++) send_item(random_request(PHASE_NOISE));
      req_valid <= 1'b0;

      while (checked_count != sent_count || pending_count != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);

      $display("%0d request items sent, %0d results checked", sent_count, checked_count);
      $display("table peaked at %0d bookings, %0d adds refused as full", peak_used, full_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
